### sv/nms_pkg.sv
// Package: shared constants, types and controller states for the 3x3 peak finder.
package nms_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int PIX_W   = 16;
	localparam int CFG_W   = 11;
	localparam int POS_W   = 10;
	localparam int SUB_W   = 18;
	localparam int ROW_LIMIT = 1024;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WIN,
		ST_DIV,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;     // latch input transaction, advance position
		logic win;      // shift window with line-store read data, write stores
		logic div_go;   // load divider operands
		logic div_step; // one quotient bit
		logic emit;     // load output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic peak;
		logic div_done;
	} sts_t;

endpackage

### sv/nms_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module nms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

### sv/nms_ctrl.sv
// Controller: per pixel read, window update, test; a peak adds division and output.
module nms_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output nms_pkg::cmd_t   cmd,
	input  nms_pkg::sts_t   sts
);

	nms_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nms_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q;
		cmd         = '0;
		in_ready    = 1'b0;
		if (out_valid_q && out_ready) out_valid_d = 1'b0;
		unique case (state_q)
			nms_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = nms_pkg::ST_READ;
				end
			end
			nms_pkg::ST_READ: state_d = nms_pkg::ST_WIN;
			nms_pkg::ST_WIN: begin
				cmd.win = 1'b1;
				state_d = nms_pkg::ST_DIV;
			end
			nms_pkg::ST_DIV: begin
				if (!sts.peak) begin
					state_d = nms_pkg::ST_IDLE;
				end else begin
					cmd.div_go = 1'b1;
					state_d    = nms_pkg::ST_OUT;
				end
			end
			nms_pkg::ST_OUT: begin
				if (!sts.div_done) begin
					cmd.div_step = 1'b1;
				end else if (!out_valid_q || out_ready) begin
					cmd.emit    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = nms_pkg::ST_IDLE;
				end
			end
			default: state_d = nms_pkg::ST_IDLE;
		endcase
	end

endmodule

### sv/nms_dp.sv
// Datapath: position counters, line stores, window, compare and two serial dividers.
module nms_dp #(
	parameter int MAX_WIDTH  = nms_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = nms_pkg::PIXEL_BITS_DEF,
	parameter int FRAC_BITS  = nms_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [nms_pkg::CFG_W-1:0]     cfg_val,
	input  logic [nms_pkg::PIX_W-1:0]     pix_in,
	input  logic                          fs_in,
	input  nms_pkg::cmd_t                 cmd,
	output nms_pkg::sts_t                 sts,
	output logic [nms_pkg::POS_W-1:0]     peak_row,
	output logic [nms_pkg::POS_W-1:0]     peak_col,
	output logic [nms_pkg::SUB_W-1:0]     sub_row,
	output logic [nms_pkg::SUB_W-1:0]     sub_col
);

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int CW   = $clog2(MAX_WIDTH + 1);
	localparam int RW   = nms_pkg::POS_W + 1;
	localparam int PB   = PIXEL_BITS;
	localparam int SW   = PB + 2;               // sum of three pixels
	localparam int NW   = PB + FRAC_BITS;       // |numerator|
	localparam int QW   = FRAC_BITS + 1;        // quotient bits needed (< 2^F)
	localparam int CNTW = $clog2(NW + 1);
	localparam int VW   = RW + FRAC_BITS + 1;

	// configuration registers
	logic [nms_pkg::CFG_W-1:0] width_q, height_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= nms_pkg::WIDTH_RESET;
			height_q <= nms_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == nms_pkg::REG_WIDTH) width_q  <= cfg_val;
			else                               height_q <= cfg_val;
		end
	end

	// effective sizes, clamped
	logic [CW-1:0] eff_w;
	logic [RW-1:0] eff_h;
	always_comb begin
		if (width_q < 11'd3) eff_w = CW'(3);
		else if ({{(32-nms_pkg::CFG_W){1'b0}}, width_q} > 32'(MAX_WIDTH)) eff_w = CW'(MAX_WIDTH);
		else eff_w = CW'(width_q);
		if (height_q < 11'd3) eff_h = RW'(3);
		else if (height_q > 11'(nms_pkg::ROW_LIMIT)) eff_h = RW'(nms_pkg::ROW_LIMIT);
		else eff_h = RW'(height_q);
	end

	// position of the incoming pixel
	logic [CW-1:0] colpos_q, col_q;
	logic [RW-1:0] rowpos_q, row_q;
	logic [CW-1:0] col_n;
	logic [RW-1:0] row_n;
	always_comb begin
		col_n = colpos_q;
		row_n = rowpos_q;
		if (fs_in) begin
			col_n = '0;
			row_n = '0;
		end else if (colpos_q >= eff_w) begin
			col_n = '0;
			row_n = rowpos_q + 1'b1;
		end
		if (row_n >= eff_h) row_n = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colpos_q <= '0;
			rowpos_q <= '0;
		end else if (cmd.take) begin
			colpos_q <= col_n + 1'b1;
			rowpos_q <= row_n;
		end
	end

	logic [PB-1:0] pix_q;
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			col_q <= col_n;
			row_q <= row_n;
			pix_q <= PB'(pix_in);
		end
	end

	// line stores
	logic [PB-1:0] old_rd, new_rd;
	nms_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_old (
		.clk(clk), .we(cmd.win), .waddr(col_q[AW-1:0]), .wdata(new_rd),
		.raddr(col_q[AW-1:0]), .rdata(old_rd)
	);
	nms_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_new (
		.clk(clk), .we(cmd.win), .waddr(col_q[AW-1:0]), .wdata(pix_q),
		.raddr(col_q[AW-1:0]), .rdata(new_rd)
	);

	// 3x3 window, index 3*row + col
	logic [PB-1:0] win_q [9];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (cmd.win) begin
			for (int i = 0; i < 3; i++) begin
				win_q[3*i]   <= win_q[3*i+1];
				win_q[3*i+1] <= win_q[3*i+2];
			end
			win_q[2] <= old_rd;
			win_q[5] <= new_rd;
			win_q[8] <= pix_q;
		end
	end

	// strict maximum test
	logic peak;
	always_comb begin
		peak = (row_q >= RW'(2)) && (col_q >= CW'(2));
		for (int i = 0; i < 9; i++)
			if (i != 4 && !(win_q[4] > win_q[i])) peak = 1'b0;
	end
	assign sts.peak = peak;

	// restoring dividers, one bit per cycle, on |num| / sum
	logic [NW-1:0]   rnum_q, cnum_q;
	logic [SW-1:0]   rden_q, cden_q;
	logic [SW:0]     rrem_q, crem_q;
	logic            rneg_q, cneg_q;
	logic [CNTW-1:0] cnt_q;
	logic [SW:0]     rtry, ctry;
	logic [SW:0]     rsub, csub;

	assign rtry = {rrem_q[SW-1:0], rnum_q[NW-1]};
	assign ctry = {crem_q[SW-1:0], cnum_q[NW-1]};
	assign rsub = rtry - {1'b0, rden_q};
	assign csub = ctry - {1'b0, cden_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_go) begin
			cnt_q <= CNTW'(NW);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end
	assign sts.div_done = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.div_go) begin
			rneg_q <= win_q[7] < win_q[1];
			cneg_q <= win_q[5] < win_q[3];
			rnum_q <= {(win_q[7] < win_q[1]) ? win_q[1] - win_q[7] : win_q[7] - win_q[1],
				{FRAC_BITS{1'b0}}};
			cnum_q <= {(win_q[5] < win_q[3]) ? win_q[3] - win_q[5] : win_q[5] - win_q[3],
				{FRAC_BITS{1'b0}}};
			rden_q <= SW'(win_q[1]) + SW'(win_q[4]) + SW'(win_q[7]);
			cden_q <= SW'(win_q[3]) + SW'(win_q[4]) + SW'(win_q[5]);
			rrem_q <= '0;
			crem_q <= '0;
		end else if (cmd.div_step) begin
			// numerator register shifts out dividend bits, takes quotient bits in
			if (!rsub[SW]) begin
				rrem_q <= rsub;
				rnum_q <= {rnum_q[NW-2:0], 1'b1};
			end else begin
				rrem_q <= rtry;
				rnum_q <= {rnum_q[NW-2:0], 1'b0};
			end
			if (!csub[SW]) begin
				crem_q <= csub;
				cnum_q <= {cnum_q[NW-2:0], 1'b1};
			end else begin
				crem_q <= ctry;
				cnum_q <= {cnum_q[NW-2:0], 1'b0};
			end
		end
	end

	// final coordinate: pos*2^F + 2^(F-1) +/- quotient
	logic [RW-1:0] prow, pcol;
	logic [VW-1:0] rbase, cbase, rval, cval;
	assign prow  = row_q - 1'b1;
	assign pcol  = RW'(col_q - 1'b1);
	assign rbase = {1'b0, prow, {FRAC_BITS{1'b0}}} + (VW'(1) << (FRAC_BITS - 1));
	assign cbase = {1'b0, pcol, {FRAC_BITS{1'b0}}} + (VW'(1) << (FRAC_BITS - 1));
	assign rval  = rneg_q ? rbase - VW'(rnum_q[QW-1:0]) : rbase + VW'(rnum_q[QW-1:0]);
	assign cval  = cneg_q ? cbase - VW'(cnum_q[QW-1:0]) : cbase + VW'(cnum_q[QW-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			peak_row <= prow[nms_pkg::POS_W-1:0];
			peak_col <= pcol[nms_pkg::POS_W-1:0];
			sub_row  <= nms_pkg::SUB_W'(rval);
			sub_col  <= nms_pkg::SUB_W'(cval);
		end
	end

endmodule

### sv/nms3x3_subpixel_peak_finder.sv
// Top level: 3x3 non-maximum suppression with sub-pixel refinement.
//  channel  | direction | handshake                | payload
//  s_axis   | in        | s_axis_tvalid/tready     | tdata pixel_value, tuser frame_start
//  m_axis   | out       | m_axis_tvalid/tready     | tdata peak_row, peak_col, sub_row, sub_col
//  cfg      | in        | cfg_valid/cfg_ready      | cfg_index, cfg_data
// A pixel without a peak passes through accept, line-store read, window and test.
// A peak then runs the bit-serial dividers before the output register is loaded.
// The output register frees the input once loaded; a stalled output holds the next peak.
// arst_n clears control, counters, window and configuration; line stores are not cleared.
module nms3x3_subpixel_peak_finder #(
	parameter int MAX_WIDTH  = nms_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = nms_pkg::PIXEL_BITS_DEF,
	parameter int FRAC_BITS  = nms_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] pixel_value
	input  logic        s_axis_tuser,   // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [9:0] peak_row, [19:10] peak_col,
	                                    // [37:20] sub_row, [55:38] sub_col
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);

	nms_pkg::cmd_t cmd;
	nms_pkg::sts_t sts;
	logic [nms_pkg::POS_W-1:0] prow, pcol;
	logic [nms_pkg::SUB_W-1:0] srow, scol;

	assign cfg_ready = 1'b1;

	nms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd(cmd), .sts(sts)
	);

	nms_dp #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
		.pix_in(s_axis_tdata), .fs_in(s_axis_tuser),
		.cmd(cmd), .sts(sts),
		.peak_row(prow), .peak_col(pcol), .sub_row(srow), .sub_col(scol)
	);

	assign m_axis_tdata = {scol, srow, pcol, prow};

endmodule

### sv/nms_checker.sv
// Port-level checker for the peak finder, bound to the top level.
module nms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);

	// output stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transaction dropped or changed while stalled");

	// an accepted pixel keeps input closed for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input reopened right after a transaction");

	// a result does not rise directly after an accepted pixel
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready, 1))
		else $error("result too soon after input");

	// peak row and column are interior, never zero
	a_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[9:0] != 10'd0 && m_axis_tdata[19:10] != 10'd0)
		else $error("border pixel reported as peak");

endmodule

bind nms3x3_subpixel_peak_finder nms_checker u_nms_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
